@@ rtl/core/hslrgb_pkg.sv @@
`timescale 1ns / 1ps

package hslrgb_pkg;

    // Default number of fraction bits; 1 << FRACTION_BITS stands for 1.0
    localparam int FRACTION_BITS_DEF = 16;

    // Register stages from the input word to the output register
    localparam int PIPE_DEPTH = 5;

    // Segment of the piecewise-linear hue ramp
    typedef logic [1:0] t_region;

    localparam t_region RG_RISE = 2'd0;  // first sixth of the turn, rising edge
    localparam t_region RG_HIGH = 2'd1;  // up to half a turn, upper level
    localparam t_region RG_FALL = 2'd2;  // up to two thirds, falling edge
    localparam t_region RG_LOW  = 2'd3;  // rest of the turn, lower level

endpackage

@@ rtl/core/hslrgb_level.sv @@
`timescale 1ns / 1ps

// Forms the lower ramp level m1, the upper level m2 and their difference d
// from saturation and lightness. Three register stages.
module hslrgb_level #(
    parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [FRACTION_BITS:0]   i_saturation,
    input  logic [FRACTION_BITS:0]   i_lightness,
    output logic [FRACTION_BITS:0]   o_m1,
    output logic [FRACTION_BITS:0]   o_m2,
    output logic [FRACTION_BITS:0]   o_d
);
    import hslrgb_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int VW = FB + 1;         // value 0..ONE
    localparam int PW = 2 * FB + 3;     // product width
    localparam int QW = PW + 1 - FB;    // rounded product width

    localparam logic [VW-1:0] ONE  = VW'(1) << FB;
    localparam logic [VW-1:0] HALF = VW'(1) << (FB - 1);

    // Stage 1: clamp inputs, pick operands, multiply
    logic [VW-1:0] w_s;
    logic [VW-1:0] w_l;
    logic          w_upper;
    logic [VW-1:0] w_opa;
    logic [VW:0]   w_opb;
    logic [PW-1:0] r_prod;
    logic          r_upper;
    logic [VW-1:0] r_l1;

    always_comb begin
        w_s     = (i_saturation > ONE) ? ONE : i_saturation;
        w_l     = (i_lightness > ONE) ? ONE : i_lightness;
        w_upper = (w_l > HALF);
        w_opa   = w_upper ? w_s : w_l;
        w_opb   = w_upper ? {1'b0, ONE - w_l} : ({1'b0, ONE} + {1'b0, w_s});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PW'(w_opa) * PW'(w_opb);
            r_upper <= w_upper;
            r_l1    <= w_l;
        end
    end

    // Stage 2: round the product and form m2
    logic [PW:0]   w_rnd;
    logic [QW-1:0] w_q;
    logic [QW-1:0] w_l2x;
    logic [QW-1:0] w_lq;
    logic [QW-1:0] w_t;
    logic [QW-1:0] w_sum;
    logic [QW-1:0] w_m2;
    logic [VW-1:0] r_m2_2;
    logic [VW-1:0] r_l2;

    always_comb begin
        w_rnd = (PW+1)'(r_prod) + (PW+1)'(HALF);
        w_q   = w_rnd[PW:FB];
        w_lq  = QW'(r_l1);
        w_l2x = w_lq << 1;
        w_t   = (w_q > w_lq) ? w_lq : w_q;
        w_sum = w_lq + w_t;
        if (r_upper) begin
            w_m2 = (w_sum > QW'(ONE)) ? QW'(ONE) : w_sum;
        end else begin
            w_m2 = (w_q > w_l2x) ? w_l2x : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2_2 <= VW'(w_m2);
            r_l2   <= r_l1;
        end
    end

    // Stage 3: m1 = 2l - m2, kept at or below m2
    logic [VW:0]   w_m1raw;
    logic [VW-1:0] r_m1;
    logic [VW-1:0] r_m2;
    logic [VW-1:0] r_d;

    assign w_m1raw = {r_l2, 1'b0} - (VW+1)'(r_m2_2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2 <= r_m2_2;
            if (w_m1raw > (VW+1)'(r_m2_2)) begin
                r_m1 <= r_m2_2;
                r_d  <= '0;
            end else begin
                r_m1 <= VW'(w_m1raw);
                r_d  <= r_m2_2 - VW'(w_m1raw);
            end
        end
    end

    assign o_m1 = r_m1;
    assign o_m2 = r_m2;
    assign o_d  = r_d;

endmodule

@@ rtl/core/hslrgb_ramp.sv @@
`timescale 1ns / 1ps

// One color channel: evaluates the hue ramp at a position in the turn.
// Five register stages; m1/m2/d are sampled in stage 4.
module hslrgb_ramp #(
    parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [FRACTION_BITS-1:0]   i_pos,
    input  logic [FRACTION_BITS:0]     i_m1,
    input  logic [FRACTION_BITS:0]     i_m2,
    input  logic [FRACTION_BITS:0]     i_d,
    output logic [FRACTION_BITS:0]     o_level
);
    import hslrgb_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int VW = FB + 1;
    localparam int XW = FB + 3;         // holds 6x and 4*ONE
    localparam int PW = 2 * VW;         // d * operand
    localparam int SW = PW + 1 - FB;    // rounded step width

    localparam logic [XW-1:0] ONE_X  = XW'(1) << FB;
    localparam logic [XW-1:0] TWO_X  = XW'(1) << (FB + 1);
    localparam logic [XW-1:0] FOUR_X = XW'(1) << (FB + 2);
    localparam logic [SW-1:0] ONE_S  = SW'(1) << FB;
    localparam logic [PW:0]   HALF_P = (PW+1)'(1) << (FB - 1);

    // Stage 1: capture position
    logic [FB-1:0] r_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= i_pos;
        end
    end

    // Stage 2: segment decode and multiplier operand
    logic [XW-1:0] w_x;
    logic [XW-1:0] w_x3;
    logic [XW-1:0] w_x6;
    logic [XW-1:0] w_fall;
    t_region       w_region;
    logic [VW-1:0] w_oper;
    t_region       r_region2;
    logic [VW-1:0] r_oper2;

    always_comb begin
        w_x    = XW'(r_pos);
        w_x3   = (w_x << 1) + w_x;
        w_x6   = w_x3 << 1;
        w_fall = FOUR_X - w_x6;
        if (w_x6 < ONE_X) begin
            w_region = RG_RISE;
            w_oper   = VW'(w_x6);
        end else if (!r_pos[FB-1]) begin
            w_region = RG_HIGH;
            w_oper   = '0;
        end else if (w_x3 < TWO_X) begin
            w_region = RG_FALL;
            w_oper   = VW'(w_fall);
        end else begin
            w_region = RG_LOW;
            w_oper   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_region2 <= w_region;
            r_oper2   <= w_oper;
        end
    end

    // Stage 3: wait for the ramp levels
    t_region       r_region3;
    logic [VW-1:0] r_oper3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_region3 <= r_region2;
            r_oper3   <= r_oper2;
        end
    end

    // Stage 4: slope product
    logic [PW-1:0] r_prod;
    t_region       r_region4;
    logic [VW-1:0] r_m1;
    logic [VW-1:0] r_m2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= PW'(i_d) * PW'(r_oper3);
            r_region4 <= r_region3;
            r_m1      <= i_m1;
            r_m2      <= i_m2;
        end
    end

    // Stage 5: round, add base level, clamp
    logic [PW:0]   w_rnd;
    logic [SW-1:0] w_lvl;
    logic [VW-1:0] r_level;

    always_comb begin
        w_rnd = (PW+1)'(r_prod) + HALF_P;
        unique case (r_region4)
            RG_RISE, RG_FALL: w_lvl = SW'(r_m1) + w_rnd[PW:FB];
            RG_HIGH:          w_lvl = SW'(r_m2);
            RG_LOW:           w_lvl = SW'(r_m1);
            default:          w_lvl = SW'(r_m1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_level <= (w_lvl > ONE_S) ? VW'(ONE_S) : VW'(w_lvl);
        end
    end

    assign o_level = r_level;

endmodule

@@ rtl/core/hsl_to_rgb_converter_top.sv @@
`timescale 1ns / 1ps

// HSL(A) to RGB(A) converter, unsigned fixed point, 1 << FRACTION_BITS = 1.0.
// Slave stream: one word per pixel (hue, saturation, lightness, alpha byte).
// Master stream: one word per pixel (red, green, blue, alpha), each 0..1.
// Saturation and lightness above 1.0 are clamped; hue wraps within one turn.
// Pipeline: an accepted word passes four register stages and then the output
// register before it reaches the master side.
// Throughput: one word per cycle while the receiver takes words. The whole
// pipeline moves on one enable: it advances whenever the output register is
// empty or being read, so s_axis_tready follows m_axis_tready combinationally
// once the output register holds a word.
// Receiver stall: the pipeline freezes; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline; the master side shows
// no valid word until new input arrives. The block keeps no other state.
module hsl_to_rgb_converter_top #(
    parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave: hue, saturation, lightness, alpha_in (lowest bits first)
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  logic [((3*FRACTION_BITS+17)/8)*8-1:0]      i_s_axis_tdata,
    // master: red, green, blue, alpha (lowest bits first)
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    output logic [((4*FRACTION_BITS+11)/8)*8-1:0]      o_m_axis_tdata
);
    import hslrgb_pkg::*;

    localparam int FB    = FRACTION_BITS;
    localparam int VW    = FB + 1;
    localparam int OUT_W = ((4 * FB + 11) / 8) * 8;

    localparam logic [VW-1:0] ONE_V = VW'(1) << FB;
    localparam logic [FB-1:0] THIRD = FB'(((longint'(1) << FB) + 1) / 3);

    // Pipeline enable and valid tracking
    logic                  w_adv;
    logic [PIPE_DEPTH-1:0] r_valid;

    assign w_adv           = !r_valid[PIPE_DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_valid[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // Unpack input word
    logic [FB-1:0] w_hue;
    logic [VW-1:0] w_saturation;
    logic [VW-1:0] w_lightness;
    logic [7:0]    w_alpha_in;

    assign w_hue        = i_s_axis_tdata[FB-1:0];
    assign w_saturation = i_s_axis_tdata[2*FB:FB];
    assign w_lightness  = i_s_axis_tdata[3*FB+1:2*FB+1];
    assign w_alpha_in   = i_s_axis_tdata[3*FB+9:3*FB+2];

    // Hue positions for the three channels, wrapping modulo one turn
    logic [FB-1:0] w_pos_red;
    logic [FB-1:0] w_pos_blue;

    assign w_pos_red  = w_hue + THIRD;
    assign w_pos_blue = w_hue - THIRD;

    // Ramp levels
    logic [VW-1:0] w_m1;
    logic [VW-1:0] w_m2;
    logic [VW-1:0] w_d;

    hslrgb_level #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_level (
        .i_clk        (i_clk),
        .i_en         (w_adv),
        .i_saturation (w_saturation),
        .i_lightness  (w_lightness),
        .o_m1         (w_m1),
        .o_m2         (w_m2),
        .o_d          (w_d)
    );

    // Channel ramps
    logic [VW-1:0] w_red;
    logic [VW-1:0] w_green;
    logic [VW-1:0] w_blue;

    hslrgb_ramp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ramp_red (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_pos   (w_pos_red),
        .i_m1    (w_m1),
        .i_m2    (w_m2),
        .i_d     (w_d),
        .o_level (w_red)
    );

    hslrgb_ramp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ramp_green (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_pos   (w_hue),
        .i_m1    (w_m1),
        .i_m2    (w_m2),
        .i_d     (w_d),
        .o_level (w_green)
    );

    hslrgb_ramp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ramp_blue (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_pos   (w_pos_blue),
        .i_m1    (w_m1),
        .i_m2    (w_m2),
        .i_d     (w_d),
        .o_level (w_blue)
    );

    // Alpha scale table: round(a * ONE / 255)
    logic [VW-1:0] w_alpha_tab [256];

    for (genvar k = 0; k < 256; k++) begin : g_alpha
        localparam longint AV = ((longint'(k) << FB) + 127) / 255;
        assign w_alpha_tab[k] = VW'(AV);
    end

    // Alpha delay line, matched to the ramp pipeline
    logic [VW-1:0] r_alpha [PIPE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_alpha[0] <= w_alpha_tab[w_alpha_in];
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_alpha[i] <= r_alpha[i-1];
            end
        end
    end

    // Pack output word
    assign o_m_axis_tdata = OUT_W'({r_alpha[PIPE_DEPTH-1], w_blue, w_green, w_red});

    // Accepted word enters the pipeline
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && i_s_axis_tvalid) |=> r_valid[0])
        else $error("accepted word did not enter the pipeline");

    // Stall freezes the valid bits
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_valid))
        else $error("pipeline moved during a stall");

    // Delivered channels stay within 0..1
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_red <= ONE_V) && (w_green <= ONE_V) &&
                            (w_blue <= ONE_V) && (r_alpha[PIPE_DEPTH-1] <= ONE_V))
        else $error("output channel above 1.0");

endmodule

@@ tb/hsl_to_rgb_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels of the HSL to RGB converter, predicts each
// output word from the accepted input word and compares them in order.
module hsl_to_rgb_checker #(
    parameter int FRACTION_BITS = hslrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic                                       i_s_axis_tvalid,
    input  logic                                       i_s_axis_tready,
    // hue, saturation, lightness, alpha_in (lowest bits first)
    input  logic [((3*FRACTION_BITS+17)/8)*8-1:0]      i_s_axis_tdata,
    input  logic                                       i_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // red, green, blue, alpha (lowest bits first)
    input  logic [((4*FRACTION_BITS+11)/8)*8-1:0]      i_m_axis_tdata,
    output int                                         o_mismatches,
    output int                                         o_pending,
    output int                                         o_checked
);
    import hslrgb_pkg::*;

    localparam int FB    = FRACTION_BITS;
    localparam int IN_W  = ((3*FB+17)/8)*8;
    localparam int SHOWN = 10;

    localparam longint unsigned ONE  = 64'd1 << FB;
    localparam longint unsigned HALF = 64'd1 << (FB - 1);
    localparam longint unsigned MASK = ONE - 1;

    typedef struct packed {
        logic [FB:0] red;
        logic [FB:0] green;
        logic [FB:0] blue;
        logic [FB:0] alpha;
    } t_rgba;

    typedef struct {
        t_rgba            want;
        logic [IN_W-1:0]  src;
    } t_pixel_expect;

    t_pixel_expect rgba_expected_q[$];
    int            mismatch_count = 0;
    int            checked_count  = 0;

    // fixed point product back to one scale, rounded to nearest
    function automatic longint unsigned round_frac(input longint unsigned v);
        return (v + HALF) >> FB;
    endfunction

    function automatic t_region ramp_segment(input longint unsigned x);
        if (6 * x < ONE)
            return RG_RISE;
        else if (2 * x < ONE)
            return RG_HIGH;
        else if (3 * x < 2 * ONE)
            return RG_FALL;
        return RG_LOW;
    endfunction

    // piecewise-linear hue ramp between the lower and upper levels
    function automatic longint unsigned hue_ramp(input longint unsigned x,
                                                 input longint unsigned lower,
                                                 input longint unsigned upper);
        longint unsigned span;
        longint unsigned level;
        span = upper - lower;
        case (ramp_segment(x))
            RG_RISE: level = lower + round_frac(span * (6 * x));
            RG_HIGH: level = upper;
            RG_FALL: level = lower + round_frac(span * (4 * ONE - 6 * x));
            default: level = lower;
        endcase
        if (level > ONE)
            level = ONE;
        return level;
    endfunction

    function automatic t_rgba hsla_to_rgba(input logic [IN_W-1:0] word);
        longint unsigned hue, sat, light, opacity;
        longint unsigned upper, lower, t, third;
        t_rgba           px;
        hue     = 64'(word[FB-1:0]) & MASK;
        sat     = 64'(word[2*FB:FB]);
        light   = 64'(word[3*FB+1:2*FB+1]);
        opacity = 64'(word[3*FB+9:3*FB+2]);
        third   = (ONE + 1) / 3;

        // saturation and lightness above one are clamped
        if (sat > ONE)
            sat = ONE;
        if (light > ONE)
            light = ONE;

        if (light <= HALF) begin
            upper = round_frac(light * (ONE + sat));
            if (upper > 2 * light)
                upper = 2 * light;
        end else begin
            t = round_frac(sat * (ONE - light));
            if (t > light)
                t = light;
            upper = light + t;
            if (upper > ONE)
                upper = ONE;
        end
        lower = 2 * light - upper;
        if (lower > upper)
            lower = upper;

        px.red   = (FB+1)'(hue_ramp((hue + third) & MASK, lower, upper));
        px.green = (FB+1)'(hue_ramp(hue, lower, upper));
        px.blue  = (FB+1)'(hue_ramp((hue + ONE - third) & MASK, lower, upper));
        px.alpha = (FB+1)'((opacity * ONE + 127) / 255);
        return px;
    endfunction

    function automatic void check_field(input string name, input logic [FB:0] want,
                                        input logic [FB:0] got,
                                        input logic [IN_W-1:0] src);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN)
                $display("%0t: %s mismatch: expected %0d, got %0d (input word %h)",
                         $realtime, name, want, got, src);
        end
    endfunction

    // score every word moved on either channel
    always @(posedge i_clk) begin
        t_pixel_expect head;
        t_rgba         got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                rgba_expected_q.push_back('{hsla_to_rgba(i_s_axis_tdata), i_s_axis_tdata});
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.red   = i_m_axis_tdata[FB:0];
                got.green = i_m_axis_tdata[2*FB+1:FB+1];
                got.blue  = i_m_axis_tdata[3*FB+2:2*FB+2];
                got.alpha = i_m_axis_tdata[4*FB+3:3*FB+3];
                if (rgba_expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN)
                        $display("%0t: unexpected output word %h", $realtime,
                                 i_m_axis_tdata);
                end else begin
                    head = rgba_expected_q.pop_front();
                    check_field("red",   head.want.red,   got.red,   head.src);
                    check_field("green", head.want.green, got.green, head.src);
                    check_field("blue",  head.want.blue,  got.blue,  head.src);
                    check_field("alpha", head.want.alpha, got.alpha, head.src);
                    checked_count++;
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= rgba_expected_q.size();
        o_checked    <= checked_count;
    end

endmodule

@@ tb/hsl_to_rgb_converter_top_test.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the HSL to RGB converter; scoring is in the checker.
module hsl_to_rgb_converter_top_test;
    import hslrgb_pkg::*;

    localparam int FB          = FRACTION_BITS_DEF;
    localparam int IN_W        = ((3*FB+17)/8)*8;
    localparam int OUT_W       = ((4*FB+11)/8)*8;
    localparam int ONE         = 1 << FB;
    localparam int HALF        = 1 << (FB - 1);
    localparam int UNIT_MAX    = (1 << (FB + 1)) - 1;
    localparam int PHASE_ITEMS = 310;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = PIPE_DEPTH + 10;
    localparam realtime TIMEOUT_NS = 200000 * 12.0;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;    // hue, saturation, lightness, alpha_in
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;    // red, green, blue, alpha

    int mismatches, pending, checked;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_ticket   = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int words_sent    = 0;

    hsl_to_rgb_converter_top #(
        .FRACTION_BITS(FB)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    hsl_to_rgb_checker #(
        .FRACTION_BITS(FB)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold whenever a new ticket shows up
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [IN_W-1:0] pack_hsla(input logic [FB-1:0] hue,
                                                  input logic [FB:0] sat,
                                                  input logic [FB:0] light,
                                                  input logic [7:0] opacity);
        logic [IN_W-1:0] word;
        word = '0;
        word[FB-1:0]          = hue;
        word[2*FB:FB]         = sat;
        word[3*FB+1:2*FB+1]   = light;
        word[3*FB+9:3*FB+2]   = opacity;
        return word;
    endfunction

    // mostly in range, with the ends, the midpoint and clamped values mixed in
    function automatic int pick_unit();
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = ONE;
            2:       v = int'($urandom_range(UNIT_MAX, ONE + 1));
            3:       v = HALF - 2 + int'($urandom_range(4));
            default: v = int'($urandom_range(ONE, 0));
        endcase
        return v;
    endfunction

    // hue either anywhere or close to a sector edge of the ramp
    function automatic int pick_hue();
        int h;
        if ($urandom_range(4) == 0)
            h = int'(($urandom_range(5) * ONE) / 6 + $urandom_range(4)) - 2;
        else
            h = int'($urandom);
        return h;
    endfunction

    // offer one word, idling first at the current sender rate
    task automatic send_hsla(input int hue, input int sat,
                             input int light, input int opacity);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pack_hsla(FB'(hue), (FB+1)'(sat), (FB+1)'(light), 8'(opacity));
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        words_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_hsla(pick_hue(), pick_unit(), pick_unit(), int'($urandom_range(255)));
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender idles lightly, receiver stalls often
        src_idle_pct  = 28;
        sink_idle_pct <= 64;

        // directed: black, white, grays, primaries, sector edges, clamping, alpha ends
        send_hsla(0, 0, 0, 0);
        send_hsla(0, ONE, HALF, 255);
        send_hsla(ONE - 1, ONE, HALF, 128);
        send_hsla(ONE / 3, ONE, HALF, 1);
        send_hsla(2 * ONE / 3, ONE, HALF, 254);
        send_hsla(ONE / 6 - 1, ONE, HALF, 127);
        send_hsla(ONE / 6, ONE, HALF, 0);
        send_hsla(ONE / 6 + 1, ONE, HALF, 255);
        send_hsla(HALF - 1, ONE, HALF, 64);
        send_hsla(HALF, ONE, HALF, 192);
        send_hsla(2 * ONE / 3 + 1, ONE, HALF, 10);
        send_hsla(2 * ONE / 3 + 2, ONE, HALF, 20);
        send_hsla(12345, 0, HALF, 200);
        send_hsla(12345, ONE, ONE, 255);
        send_hsla(54321, ONE, 0, 0);
        send_hsla(7000, UNIT_MAX, UNIT_MAX, 255);
        send_hsla(40000, ONE + 1, HALF + 1, 3);
        send_hsla(30000, ONE, HALF + 1, 100);
        send_hsla(30000, 1, HALF - 1, 101);
        send_hsla(60000, UNIT_MAX, 1, 33);
        send_hsla(ONE / 3 - 1, HALF, 3 * ONE / 4, 77);
        send_hsla(5 * ONE / 6, HALF, ONE / 4, 250);

        send_random(PHASE_ITEMS / 2);
        hold_ticket <= hold_ticket + 1;
        send_random(PHASE_ITEMS / 2);

        // phase 2: the other way round
        src_idle_pct  = 64;
        sink_idle_pct <= 28;
        send_random(PHASE_ITEMS);

        // phase 3: full rate both sides, with a long receiver hold to fill the pipe
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        send_random(PHASE_ITEMS / 3);
        hold_ticket <= hold_ticket + 1;
        send_random(PHASE_ITEMS - PHASE_ITEMS / 3);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;

        // drain
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d HSLA words (sector edges, clamped saturation/lightness, alpha ends),",
                 words_sent);
        $display("checked %0d RGBA words under three stall mixes and two long holds.",
                 checked);
        if (pending != 0)
            $display("%0d expected words never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout after %0t", $realtime);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
